[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Invariant.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

[rtl/odr_pkg.sv]
`default_nettype none

package odr_pkg;

   localparam int MAX_DISTINCT = 64;
   localparam int ADDR_W       = $clog2(MAX_DISTINCT);
   localparam int VALUE_W      = 32;
   localparam int DCOUNT_W     = 7;

   localparam logic [DCOUNT_W-1:0] MAX_COUNT = DCOUNT_W'(MAX_DISTINCT);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  out_value;
      logic                       keep;
      logic        [DCOUNT_W-1:0] distinct_count;
      logic                       out_last;
      logic                       overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture transaction, clear pointer and hit flag
      logic rd;       // read store entry at pointer
      logic compare;  // latch match result
      logic step;     // advance pointer
      logic finish;   // update store and count, load result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic count_zero;
      logic match;
      logic scan_end;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/ordered_duplicate_removal_core.sv]
// Channel  Direction  Payload          Handshake
// req_     in         odr_pkg::req_type  req_valid / req_stall
// rsp_     out        odr_pkg::rsp_type  rsp_valid / rsp_stall
//
// One transaction at a time: accepted in idle, then the stored values are
// read from the single-port store and compared one entry at a time, a read
// state then a compare state per entry, over at most the kept count of
// entries (up to 64), ending early on a match.
// Reset (synchronous, active high) clears the kept count, the state and the
// result valid; store contents need no clearing since only entries below the
// count are read. A stalled result holds in the output register while the
// next transaction is accepted and scanned; finish waits for it to drain.
`default_nettype none

module ordered_duplicate_removal_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire odr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output odr_pkg::rsp_type      rsp_data
);
   import odr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: idle / read / compare / finish
   odr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // store, scan pointer, kept count and result register
   odr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/odr_ctrl.sv]
`default_nettype none

module odr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire odr_pkg::status_type status,
   output odr_pkg::cmd_type        cmd
);
   import odr_pkg::*;

`include "assert_macros.svh"

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.count_zero ? ST_FINISH : ST_READ;
            end
         end
         ST_READ:   state_in = ST_CMP;
         ST_CMP: begin
            if (status.match || status.scan_end) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_READ:   cmd.rd = 1'b1;
         ST_CMP: begin
            cmd.compare = 1'b1;
            cmd.step    = !(status.match || status.scan_end);
         end
         ST_FINISH: cmd.finish = status.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   `ASSERT_NEXT(a_finish_to_idle, clock, reset, cmd.finish, state_ff == ST_IDLE, "finish did not return to idle")
   `ASSERT_NEXT(a_read_then_cmp, clock, reset, state_ff == ST_READ, state_ff == ST_CMP, "read not followed by compare")

endmodule

`default_nettype wire

[rtl/odr_datapath.sv]
`default_nettype none

module odr_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire odr_pkg::req_type    req_data,
   input  wire odr_pkg::cmd_type    cmd,
   output odr_pkg::status_type      status,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output odr_pkg::rsp_type         rsp_data
);
   import odr_pkg::*;

`include "assert_macros.svh"

   logic [VALUE_W-1:0] seen_mem [MAX_DISTINCT];

   req_type             item_ff;
   logic [ADDR_W-1:0]   ptr_ff;
   logic [VALUE_W-1:0]  rd_data_ff;
   logic                hit_ff;
   logic [DCOUNT_W-1:0] count_ff, count_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                full;
   logic                store_new;
   logic [DCOUNT_W-1:0] ptr_next;

   assign full      = (count_ff == MAX_COUNT);
   assign store_new = cmd.finish && !hit_ff && !full;
   assign ptr_next  = DCOUNT_W'(ptr_ff) + DCOUNT_W'(1);

   assign status.count_zero = (count_ff == '0);
   assign status.match      = (rd_data_ff == item_ff.value);
   assign status.scan_end   = (ptr_next == count_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // store write and registered read
   always_ff @(posedge clock) begin
      if (store_new) begin
         seen_mem[count_ff[ADDR_W-1:0]] <= item_ff.value;
      end
      if (cmd.rd) begin
         rd_data_ff <= seen_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
         ptr_ff  <= '0;
         hit_ff  <= 1'b0;
      end else begin
         if (cmd.compare) hit_ff <= status.match;
         if (cmd.step)    ptr_ff <= ptr_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = rsp_ff;
      if (cmd.finish) begin
         rsp_in.out_value      = item_ff.value;
         rsp_in.keep           = store_new;
         rsp_in.distinct_count = store_new ? count_ff + DCOUNT_W'(1) : count_ff;
         rsp_in.out_last       = item_ff.last;
         rsp_in.overflow       = !hit_ff && full;
         if (item_ff.last) begin
            count_in = '0;
         end else if (store_new) begin
            count_in = count_ff + DCOUNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= MAX_COUNT, "kept count above store depth")
   `ASSERT_IMPL(a_keep_ovf_excl, clock, reset, rsp_valid_ff, !(rsp_ff.keep && rsp_ff.overflow), "keep and overflow both set")
   `ASSERT_NEXT(a_last_clears, clock, reset, cmd.finish && item_ff.last, count_ff == '0, "count not cleared after last")

endmodule

`default_nettype wire

[verif/tb_ordered_duplicate_removal_core.sv]
`timescale 1ns / 1ps

module tb_ordered_duplicate_removal_core;
   import odr_pkg::*;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam int RANDOM_ITEMS = 700;
   // a transaction scans at most MAX_DISTINCT entries
   localparam int DRAIN_CYCLES = 2 * MAX_DISTINCT + 12;

   // Scoreboard: tracks the distinct values of the current list and queues
   // the verdict each accepted element must produce.
   class dedup_scoreboard;
      logic signed [VALUE_W-1:0] kept_vals [MAX_DISTINCT];
      int                        kept_count = 0;
      rsp_type                   verdicts_due [$];
      int                        errors = 0;

      function void note_element(req_type r);
         rsp_type v;
         bit      found;
         int      i;
         found = 1'b0;
         for (i = 0; i < kept_count; i++)
            if (kept_vals[i] == r.value)
               found = 1'b1;
         v.out_value = r.value;
         v.out_last  = r.last;
         v.keep      = 1'b0;
         v.overflow  = 1'b0;
         if (!found) begin
            if (kept_count < MAX_DISTINCT) begin
               kept_vals[kept_count] = r.value;
               kept_count++;
               v.keep = 1'b1;
            end else begin
               // store full: new value is dropped, and so is every later copy
               v.overflow = 1'b1;
            end
         end
         v.distinct_count = DCOUNT_W'(kept_count);
         verdicts_due.push_back(v);
         // list closed: next element starts an empty store
         if (r.last)
            kept_count = 0;
      endfunction

      function void check_verdict(rsp_type got);
         rsp_type want;
         bit      bad;
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result, got %h", $time, got);
            errors++;
            return;
         end
         want = verdicts_due.pop_front();
         bad  = 1'b0;
         if (got.out_value !== want.out_value) begin
            $display("%0t: out_value expected %0d got %0d", $time, want.out_value,
                     got.out_value);
            bad = 1'b1;
         end
         if (got.keep !== want.keep) begin
            $display("%0t: keep expected %b got %b", $time, want.keep, got.keep);
            bad = 1'b1;
         end
         if (got.distinct_count !== want.distinct_count) begin
            $display("%0t: distinct_count expected %0d got %0d", $time,
                     want.distinct_count, got.distinct_count);
            bad = 1'b1;
         end
         if (got.out_last !== want.out_last) begin
            $display("%0t: out_last expected %b got %b", $time, want.out_last,
                     got.out_last);
            bad = 1'b1;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %b got %b", $time, want.overflow,
                     got.overflow);
            bad = 1'b1;
         end
         if (bad)
            errors++;
      endfunction
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   dedup_scoreboard sb = new;

   // list under construction, sent in order by send_list
   req_type                   pending_list [$];
   // small value pool so random lists carry plenty of repeats
   logic signed [VALUE_W-1:0] pool [8];
   // when set, neither side idles: back-to-back transactions
   bit                        burst_mode = 1'b0;
   int                        sent = 0;

   ordered_duplicate_removal_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("tb_ordered_duplicate_removal_core failed");
      $finish;
   end

   // Result side: draw a random stall before taking each transaction.
   // Stall may sit high before the result even shows up, so gaps land on
   // every phase of the scan.
   initial begin : rsp_side
      int hold;
      forever begin
         hold = burst_mode ? 0 : $urandom_range(0, 3);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid === 1'b1)) @(posedge clock);
      end
   end

   // Monitor: any result taken at this edge goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_verdict(rsp_data);
   end

   function automatic void add_item(logic signed [VALUE_W-1:0] v, logic lst);
      req_type r;
      r.value = v;
      r.last  = lst;
      pending_list.push_back(r);
   endfunction

   // Mostly pool values, with the field extremes mixed in.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         3:       return -1;
         default: return pool[$urandom_range(0, 7)];
      endcase
   endfunction

   // One transaction on the request side. Valid is left high on return so
   // the next call can follow without a bubble; callers that go quiet must
   // drop it themselves (see wait_drain).
   task automatic send_element(req_type r);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_element(r);
      sent++;
   endtask

   task automatic send_list();
      while (pending_list.size() != 0)
         send_element(pending_list.pop_front());
   endtask

   // Sender goes quiet until every expected result is back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.verdicts_due.size() != 0) @(posedge clock);
   endtask

   // Overfill the store: MAX_DISTINCT distinct values plus some extra new
   // ones, with repeats of earlier values (stored or dropped) sprinkled in.
   function automatic void build_fill_list();
      logic [VALUE_W-1:0]        base;
      logic [VALUE_W-1:0]        stride;
      logic signed [VALUE_W-1:0] v;
      logic signed [VALUE_W-1:0] past [$];
      int                        fresh;
      int                        total;
      base   = $urandom;
      stride = $urandom | 32'd1;   // odd stride keeps the sequence distinct
      total  = MAX_DISTINCT + $urandom_range(1, 12);
      fresh  = 0;
      while (fresh < total) begin
         if (past.size() != 0 && $urandom_range(0, 7) == 0) begin
            v = past[$urandom_range(0, past.size() - 1)];
         end else begin
            v = base + VALUE_W'(fresh) * stride;
            fresh++;
         end
         past.push_back(v);
         add_item(v, 1'b0);
      end
      // a few trailing repeats, including overflowed values
      repeat ($urandom_range(0, 4))
         add_item(past[$urandom_range(0, past.size() - 1)], 1'b0);
      add_item(past[$urandom_range(0, past.size() - 1)], 1'b1);
   endfunction

   initial begin : stimulus
      int kind;
      int len;
      int i;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // extremes, duplicates of extremes, zero and minus one
      add_item(VAL_MIN, 1'b0);
      add_item(VAL_MAX, 1'b0);
      add_item('0, 1'b0);
      add_item(-1, 1'b0);
      add_item(VAL_MAX, 1'b0);
      add_item(VAL_MIN, 1'b0);
      add_item(1, 1'b0);
      add_item('0, 1'b1);
      // single-element lists; the second shows the store was cleared
      add_item(VAL_MAX, 1'b1);
      add_item(VAL_MAX, 1'b1);
      // alternating bit patterns
      add_item(32'sh5555_5555, 1'b0);
      add_item(32'shAAAA_AAAA, 1'b0);
      add_item(32'sh5555_5555, 1'b0);
      add_item(32'shAAAA_AAAA, 1'b1);
      // same value throughout
      add_item(7, 1'b0);
      add_item(7, 1'b0);
      add_item(7, 1'b1);
      send_list();
      wait_drain();

      // --- random lists ---
      while (sent < RANDOM_ITEMS) begin
         burst_mode = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            // well-formed list from a small pool: lots of duplicates
            for (i = 0; i < 8; i++)
               pool[i] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom;
            len = $urandom_range(1, 24);
            for (i = 0; i < len; i++)
               add_item(pick_value(), i == len - 1);
         end else if (kind < 8) begin
            // wide random values, mostly distinct
            len = $urandom_range(1, 16);
            for (i = 0; i < len; i++)
               add_item($urandom, i == len - 1);
         end else if (kind == 8) begin
            build_fill_list();
         end else begin
            // noise: random last marks, list may stay open into the next one
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
               add_item(($urandom_range(0, 1) != 0) ? $urandom : pick_value(),
                        $urandom_range(0, 2) == 0);
         end
         send_list();
         if ($urandom_range(0, 39) == 0)
            wait_drain();
      end

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
         $display("tb_ordered_duplicate_removal_core passed");
      end else begin
         $display("tb_ordered_duplicate_removal_core failed");
      end
      $finish;
   end

endmodule
